@@ rtl/sbm_pkg.sv @@
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared constants, register indexes and types of the SAD stereo matcher.
// ----------------------------------------------------------------------------
package sbm_pkg;

  localparam int unsigned MAX_WIDTH    = 256;
  localparam int unsigned MAX_HEIGHT   = 256;
  localparam int unsigned MAX_CHANNELS = 3;
  localparam int unsigned MAX_RADIUS   = 7;

  localparam int unsigned COL_W   = 8;
  localparam int unsigned ROW_W   = 8;
  localparam int unsigned CH_W    = 2;
  localparam int unsigned ADDR_W  = CH_W + ROW_W + COL_W;
  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;

  localparam int unsigned AGG_W   = 18;
  localparam int unsigned CAP_W   = 10;
  localparam int unsigned DIV_NW  = 36;
  localparam int unsigned DIV_DW  = 22;
  localparam int unsigned DIV_CW  = 6;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_DISP  = 3'd0,
    REG_MAX_DISP  = 3'd1,
    REG_DIRECTION = 3'd2,
    REG_RADIUS    = 3'd3,
    REG_THRESHOLD = 3'd4,
    REG_WIDTH     = 3'd5,
    REG_HEIGHT    = 3'd6,
    REG_CHANNELS  = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP_WIN,
    ST_SETUP_CNT,
    ST_SETUP_CAP,
    ST_SCAN,
    ST_DRAIN,
    ST_CALC,
    ST_PREP,
    ST_SUB_WAIT,
    ST_CONF_START,
    ST_CONF_WAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

endpackage

@@ rtl/sbm_if.sv @@
// ----------------------------------------------------------------------------
// sbm_if
// Valid/ready channels of the matcher: query/load items and match results.
// ----------------------------------------------------------------------------
interface sbm_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] col;
  logic [7:0] row;
  logic [1:0] channel;
  logic [7:0] ref_value;
  logic [7:0] tmpl_value;

  modport source (output valid, command, col, row, channel, ref_value, tmpl_value,
                  input ready);
  modport sink (input valid, command, col, row, channel, ref_value, tmpl_value,
                output ready);
endinterface

interface sbm_out_if;
  logic        valid;
  logic        ready;
  logic        match_found;
  logic [16:0] disparity_fixed;
  logic [15:0] confidence;
  logic        subpixel_applied;

  modport source (output valid, match_found, disparity_fixed, confidence,
                  subpixel_applied, input ready);
  modport sink (input valid, match_found, disparity_fixed, confidence,
                subpixel_applied, output ready);
endinterface

@@ rtl/sad_stereo_block_matcher_core.sv @@
// A query result is valid after its transfer once the scan (D disparities, n window pixels
//   after clipping, C channels) and the final divisions have finished.
// One pixel-channel sample pair is read per cycle from the two sample memories;
//   the final divisions run one quotient bit per cycle (skipped if /0).
// Items are taken one at a time; a new item is taken once the query is done.
// Reset sets the configuration to defaults and clears state and valids; sample memories are undefined until loaded.
// ----------------------------------------------------------------------------
// sad_stereo_block_matcher_core
// SAD stereo matcher with subpixel refinement and ratio confidence.
// ----------------------------------------------------------------------------
module sad_stereo_block_matcher_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sbm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sbm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  sbm_in_if.sink                         in_i,
  sbm_out_if.source                      out_o
);

  // configuration
  logic [7:0] mind_q, maxd_q, thr_q;
  logic       dir_q;
  logic [2:0] rad_q;
  logic [8:0] wid_q, hgt_q;
  logic [1:0] chn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mind_q <= 8'd0;
      maxd_q <= 8'd64;
      dir_q  <= 1'b0;
      rad_q  <= 3'd1;
      thr_q  <= 8'd100;
      wid_q  <= 9'd256;
      hgt_q  <= 9'd256;
      chn_q  <= 2'd3;
    end else if (cfg_we_i) begin
      case (sbm_pkg::cfg_reg_e'(cfg_idx_i))
        sbm_pkg::REG_MIN_DISP:  mind_q <= cfg_wdata_i[7:0];
        sbm_pkg::REG_MAX_DISP:  maxd_q <= cfg_wdata_i[7:0];
        sbm_pkg::REG_DIRECTION: dir_q  <= cfg_wdata_i[0];
        sbm_pkg::REG_RADIUS:    rad_q  <= cfg_wdata_i[2:0];
        sbm_pkg::REG_THRESHOLD: thr_q  <= cfg_wdata_i[7:0];
        sbm_pkg::REG_WIDTH:     wid_q  <= cfg_wdata_i;
        sbm_pkg::REG_HEIGHT:    hgt_q  <= cfg_wdata_i;
        sbm_pkg::REG_CHANNELS:  chn_q  <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  sbm_pkg::state_e state_q, state_d;

  // query setup
  logic [7:0]  qcol_q, qrow_q;
  logic [7:0]  x0_q, x1_q, y0_q, y1_q, wm1_q;
  logic [1:0]  nc_q;
  logic [sbm_pkg::CAP_W-1:0] cap_q;
  logic signed [8:0] dmin_q, dmax_q;
  logic        sdir_q;
  logic [7:0]  n_q;
  logic [sbm_pkg::AGG_W-1:0] tn_q;

  // scan counters
  logic signed [8:0] d_q;
  logic [7:0]  wx_q, wy_q;
  logic [1:0]  c_q;

  // read pipeline tags
  logic        p_vld_q, p_lastc_q, p_lastpix_q;
  logic signed [8:0] p_d_q;

  // accumulation and minima
  logic [sbm_pkg::CAP_W-1:0] s_q, s_d;
  logic [sbm_pkg::AGG_W-1:0] agg_q, agg_d;
  logic [sbm_pkg::AGG_W-1:0] min1_q, min2_q, min3_q, prev_q, next_q, last_q;
  logic [sbm_pkg::AGG_W-1:0] min1_d, min2_d, min3_d, prev_d, next_d, last_d;
  logic signed [8:0] best_q, best_d;
  logic        found_q, found_d;

  // finish
  logic        sub_q, neg_q;
  logic [19:0] sden_q;
  logic [25:0] san_q;
  logic [sbm_pkg::AGG_W-1:0] cnum_q, cden_q;
  logic [16:0] disp_q;
  logic [15:0] conf_q;

  // output register
  logic        ovld_q;
  logic        o_found_q, o_sub_q;
  logic [16:0] o_disp_q;
  logic [15:0] o_conf_q;

  logic in_xfer, out_xfer;
  assign in_xfer  = in_i.valid & in_i.ready;
  assign out_xfer = ovld_q & out_o.ready;
  assign in_i.ready = (state_q == sbm_pkg::ST_IDLE);

  // memories
  logic        st_we;
  logic [7:0]  rref, rtmpl;
  logic [7:0]  xt;
  logic signed [10:0] xt_s;

  assign st_we = in_xfer && (sbm_pkg::cmd_e'(in_i.command) == sbm_pkg::CMD_LOAD)
                 && (in_i.channel < 2'(sbm_pkg::MAX_CHANNELS));

  always_comb begin
    xt_s = sdir_q ? ($signed({3'b000, wx_q}) + 11'(d_q))
                  : ($signed({3'b000, wx_q}) - 11'(d_q));
    if (xt_s < 0) begin
      xt = 8'd0;
    end else if (xt_s > $signed({3'b000, wm1_q})) begin
      xt = wm1_q;
    end else begin
      xt = xt_s[7:0];
    end
  end

  sbm_store u_store (
    .clk_i        (clk_i),
    .we_i         (st_we),
    .waddr_i      ({in_i.channel, in_i.row, in_i.col}),
    .wref_i       (in_i.ref_value),
    .wtmpl_i      (in_i.tmpl_value),
    .raddr_ref_i  ({c_q, wy_q, wx_q}),
    .raddr_tmpl_i ({c_q, wy_q, xt}),
    .rref_o       (rref),
    .rtmpl_o      (rtmpl)
  );

  // divider
  sbm_pkg::div_req_t div_req;
  logic              div_done;
  logic [sbm_pkg::DIV_NW-1:0] div_quot;

  sbm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // setup arithmetic
  logic [8:0] w_c, h_c, xr, yr;
  logic [7:0] wm1_c, hm1_c, x_c, y_c;
  logic [1:0] nc_c;

  always_comb begin
    w_c   = (wid_q == 9'd0) ? 9'd1 : ((wid_q > 9'(sbm_pkg::MAX_WIDTH)) ?
            9'(sbm_pkg::MAX_WIDTH) : wid_q);
    h_c   = (hgt_q == 9'd0) ? 9'd1 : ((hgt_q > 9'(sbm_pkg::MAX_HEIGHT)) ?
            9'(sbm_pkg::MAX_HEIGHT) : hgt_q);
    wm1_c = 8'(w_c - 9'd1);
    hm1_c = 8'(h_c - 9'd1);
    x_c   = (qcol_q > wm1_c) ? wm1_c : qcol_q;
    y_c   = (qrow_q > hm1_c) ? hm1_c : qrow_q;
    xr    = {1'b0, x_c} + {6'd0, rad_q};
    yr    = {1'b0, y_c} + {6'd0, rad_q};
    nc_c  = (chn_q == 2'd0) ? 2'd1 : ((chn_q > 2'(sbm_pkg::MAX_CHANNELS)) ?
            2'(sbm_pkg::MAX_CHANNELS) : chn_q);
  end

  // data stage
  logic [7:0] diff;
  logic [sbm_pkg::CAP_W-1:0] s_new, pix;
  logic [sbm_pkg::AGG_W-1:0] agg_new;
  logic [sbm_pkg::AGG_W-1:0] tn_c;
  logic signed [8:0] dmax_sx;

  assign tn_c = {8'd0, cap_q} * {10'd0, n_q};

  always_comb begin
    diff    = (rref > rtmpl) ? (rref - rtmpl) : (rtmpl - rref);
    s_new   = s_q + {2'b00, diff};
    pix     = (s_new < cap_q) ? s_new : cap_q;
    agg_new = agg_q + {8'd0, pix};
    s_d     = s_q;
    agg_d   = agg_q;
    min1_d  = min1_q;
    min2_d  = min2_q;
    min3_d  = min3_q;
    prev_d  = prev_q;
    next_d  = next_q;
    last_d  = last_q;
    best_d  = best_q;
    found_d = found_q;
    if (state_q == sbm_pkg::ST_SETUP_CAP) begin
      s_d     = '0;
      agg_d   = '0;
      min1_d  = tn_c;
      min2_d  = tn_c;
      min3_d  = tn_c;
      prev_d  = tn_c;
      next_d  = tn_c;
      last_d  = tn_c;
      best_d  = '0;
      found_d = 1'b0;
    end else if (p_vld_q) begin
      if (p_lastc_q) begin
        s_d   = '0;
        agg_d = p_lastpix_q ? '0 : agg_new;
      end else begin
        s_d = s_new;
      end
      if (p_lastc_q && p_lastpix_q) begin
        if (agg_new < min1_q) begin
          min3_d  = min2_q;
          min2_d  = min1_q;
          min1_d  = agg_new;
          prev_d  = last_q;
          next_d  = tn_q;
          best_d  = p_d_q;
          found_d = 1'b1;
        end else if (agg_new < min2_q) begin
          min3_d = min2_q;
          min2_d = agg_new;
        end else if (agg_new < min3_q) begin
          min3_d = agg_new;
        end
        if (p_d_q == best_d + 9'sd1) begin
          next_d = agg_new;
        end
        last_d = agg_new;
      end
    end
  end

  // finish arithmetic
  logic [sbm_pkg::AGG_W-1:0] pn_c;
  logic [18:0] den_half_c;

  assign pn_c = (prev_q < next_q) ? prev_q : next_q;
  assign den_half_c = {1'b0, next_q} + {1'b0, prev_q} - {min1_q, 1'b0};
  assign dmax_sx = dmax_q;

  // control
  logic scan_lastc, scan_lastx, scan_lasty, scan_lastd;
  assign scan_lastc = (c_q == nc_q - 2'd1);
  assign scan_lastx = (wx_q == x1_q);
  assign scan_lasty = (wy_q == y1_q);
  assign scan_lastd = (d_q == dmax_sx);

  always_comb begin
    state_d = state_q;
    div_req = '0;
    case (state_q)
      sbm_pkg::ST_IDLE: begin
        if (in_xfer && (sbm_pkg::cmd_e'(in_i.command) == sbm_pkg::CMD_QUERY)) begin
          state_d = sbm_pkg::ST_SETUP_WIN;
        end
      end
      sbm_pkg::ST_SETUP_WIN: state_d = sbm_pkg::ST_SETUP_CNT;
      sbm_pkg::ST_SETUP_CNT: state_d = sbm_pkg::ST_SETUP_CAP;
      sbm_pkg::ST_SETUP_CAP: begin
        state_d = (dmax_q < dmin_q) ? sbm_pkg::ST_CALC : sbm_pkg::ST_SCAN;
      end
      sbm_pkg::ST_SCAN: begin
        if (scan_lastc && scan_lastx && scan_lasty && scan_lastd) begin
          state_d = sbm_pkg::ST_DRAIN;
        end
      end
      sbm_pkg::ST_DRAIN: state_d = sbm_pkg::ST_CALC;
      sbm_pkg::ST_CALC:  state_d = sbm_pkg::ST_PREP;
      sbm_pkg::ST_PREP: begin
        if (sub_q && (sden_q != 20'd0)) begin
          div_req.start = 1'b1;
          div_req.num   = sbm_pkg::DIV_NW'({san_q, 1'b0}) + sbm_pkg::DIV_NW'(sden_q);
          div_req.den   = sbm_pkg::DIV_DW'({sden_q, 1'b0});
          state_d = sbm_pkg::ST_SUB_WAIT;
        end else begin
          state_d = sbm_pkg::ST_CONF_START;
        end
      end
      sbm_pkg::ST_SUB_WAIT: begin
        if (div_done) begin
          state_d = sbm_pkg::ST_CONF_START;
        end
      end
      sbm_pkg::ST_CONF_START: begin
        if (cden_q != '0) begin
          div_req.start = 1'b1;
          div_req.num   = sbm_pkg::DIV_NW'({cnum_q, 16'd0}) +
                          sbm_pkg::DIV_NW'(cden_q >> 1);
          div_req.den   = sbm_pkg::DIV_DW'(cden_q);
          state_d = sbm_pkg::ST_CONF_WAIT;
        end else begin
          state_d = sbm_pkg::ST_EMIT;
        end
      end
      sbm_pkg::ST_CONF_WAIT: begin
        if (div_done) begin
          state_d = sbm_pkg::ST_EMIT;
        end
      end
      sbm_pkg::ST_EMIT: begin
        if (!ovld_q || out_o.ready) begin
          state_d = sbm_pkg::ST_IDLE;
        end
      end
      default: state_d = sbm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbm_pkg::ST_IDLE;
      p_vld_q <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      p_vld_q <= (state_q == sbm_pkg::ST_SCAN);
      if (state_q == sbm_pkg::ST_EMIT && (!ovld_q || out_o.ready)) begin
        ovld_q <= 1'b1;
      end else if (out_xfer) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_lastc_q   <= scan_lastc;
    p_lastpix_q <= scan_lastx && scan_lasty;
    p_d_q       <= d_q;
    s_q     <= s_d;
    agg_q   <= agg_d;
    min1_q  <= min1_d;
    min2_q  <= min2_d;
    min3_q  <= min3_d;
    prev_q  <= prev_d;
    next_q  <= next_d;
    last_q  <= last_d;
    best_q  <= best_d;
    found_q <= found_d;
    case (state_q)
      sbm_pkg::ST_IDLE: begin
        qcol_q <= in_i.col;
        qrow_q <= in_i.row;
      end
      sbm_pkg::ST_SETUP_WIN: begin
        x0_q   <= (x_c > {5'd0, rad_q}) ? (x_c - {5'd0, rad_q}) : 8'd0;
        y0_q   <= (y_c > {5'd0, rad_q}) ? (y_c - {5'd0, rad_q}) : 8'd0;
        x1_q   <= (xr < w_c) ? xr[7:0] : wm1_c;
        y1_q   <= (yr < h_c) ? yr[7:0] : hm1_c;
        wm1_q  <= wm1_c;
        nc_q   <= nc_c;
        cap_q  <= {2'b00, thr_q} * {8'd0, nc_c};
        dmin_q <= 9'(signed'(mind_q));
        dmax_q <= 9'(signed'(maxd_q));
        sdir_q <= dir_q;
      end
      sbm_pkg::ST_SETUP_CNT: begin
        n_q <= {4'd0, x1_q[3:0] - x0_q[3:0] + 4'd1} *
               {4'd0, y1_q[3:0] - y0_q[3:0] + 4'd1};
      end
      sbm_pkg::ST_SETUP_CAP: begin
        tn_q <= tn_c;
        d_q  <= dmin_q;
        wx_q <= x0_q;
        wy_q <= y0_q;
        c_q  <= '0;
      end
      sbm_pkg::ST_SCAN: begin
        if (!scan_lastc) begin
          c_q <= c_q + 2'd1;
        end else begin
          c_q <= '0;
          if (!scan_lastx) begin
            wx_q <= wx_q + 8'd1;
          end else begin
            wx_q <= x0_q;
            if (!scan_lasty) begin
              wy_q <= wy_q + 8'd1;
            end else begin
              wy_q <= y0_q;
              d_q  <= d_q + 9'sd1;
            end
          end
        end
      end
      sbm_pkg::ST_CALC: begin
        sub_q  <= (pn_c <= min2_q);
        neg_q  <= (next_q < prev_q);
        sden_q <= {den_half_c, 1'b0};
        san_q  <= {((next_q < prev_q) ? (prev_q - next_q) : (next_q - prev_q)), 8'd0};
        cnum_q <= (pn_c <= min2_q) ? (min3_q - min1_q) : (min2_q - min1_q);
        cden_q <= (pn_c <= min2_q) ? min3_q : min2_q;
        disp_q <= {best_q, 8'd0};
        conf_q <= '0;
      end
      sbm_pkg::ST_SUB_WAIT: begin
        if (div_done) begin
          disp_q <= neg_q ? (disp_q + div_quot[16:0]) : (disp_q - div_quot[16:0]);
        end
      end
      sbm_pkg::ST_CONF_WAIT: begin
        if (div_done) begin
          conf_q <= (div_quot > sbm_pkg::DIV_NW'(16'hFFFF)) ? 16'hFFFF : div_quot[15:0];
        end
      end
      sbm_pkg::ST_EMIT: begin
        if (!ovld_q || out_o.ready) begin
          o_found_q <= found_q;
          o_sub_q   <= sub_q;
          o_disp_q  <= disp_q;
          o_conf_q  <= conf_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid            = ovld_q;
  assign out_o.match_found      = o_found_q;
  assign out_o.disparity_fixed  = o_disp_q;
  assign out_o.confidence       = o_conf_q;
  assign out_o.subpixel_applied = o_sub_q;

  a_div_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == sbm_pkg::ST_SUB_WAIT || state_q == sbm_pkg::ST_CONF_WAIT))
    else $error("divider finished outside a wait state");

  a_chan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sbm_pkg::ST_SCAN) |-> (c_q < nc_q))
    else $error("channel counter beyond channels in use");

  a_minima_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sbm_pkg::ST_CALC) |-> (min1_q <= min2_q && min2_q <= min3_q))
    else $error("minima out of order");

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sbm_pkg::ST_SCAN) |=> !$past(st_we))
    else $error("sample write during scan");

endmodule

@@ rtl/sbm_store.sv @@
// ----------------------------------------------------------------------------
// sbm_store
// Reference and template sample memories, one write and one read port each.
// ----------------------------------------------------------------------------
module sbm_store (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [sbm_pkg::ADDR_W-1:0] waddr_i,
  input  logic [7:0]                 wref_i,
  input  logic [7:0]                 wtmpl_i,
  input  logic [sbm_pkg::ADDR_W-1:0] raddr_ref_i,
  input  logic [sbm_pkg::ADDR_W-1:0] raddr_tmpl_i,
  output logic [7:0]                 rref_o,
  output logic [7:0]                 rtmpl_o
);

  logic [7:0] ref_mem  [0:sbm_pkg::STORE_DEPTH-1];
  logic [7:0] tmpl_mem [0:sbm_pkg::STORE_DEPTH-1];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      ref_mem[waddr_i]  <= wref_i;
      tmpl_mem[waddr_i] <= wtmpl_i;
    end
    rref_o  <= ref_mem[raddr_ref_i];
    rtmpl_o <= tmpl_mem[raddr_tmpl_i];
  end

endmodule

@@ rtl/sbm_div.sv @@
// ----------------------------------------------------------------------------
// sbm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sbm_pkg::div_req_t          req_i,
  output logic                       done_o,
  output logic [sbm_pkg::DIV_NW-1:0] quot_o
);

  logic [sbm_pkg::DIV_NW-1:0] num_q, num_d;
  logic [sbm_pkg::DIV_DW:0]   rem_q, rem_d;
  logic [sbm_pkg::DIV_DW-1:0] den_q, den_d;
  logic [sbm_pkg::DIV_CW-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [sbm_pkg::DIV_DW:0]   trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[sbm_pkg::DIV_DW-1:0], num_q[sbm_pkg::DIV_NW-1]};
    if (req_i.start) begin
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        num_d = {num_q[sbm_pkg::DIV_NW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[sbm_pkg::DIV_NW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == sbm_pkg::DIV_CW'(sbm_pkg::DIV_NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule
